### hdl/pwlc_pkg.sv
// Shared types, constants and helpers of the pin-wheel and lug-cage cipher.
package pwlc_pkg;

	localparam int CHAR_W     = 7;
	localparam int LOW_W      = 6;
	localparam int PAT_W      = 6;
	localparam int NUM_WHEELS = 6;
	localparam int POS_W      = 5;
	localparam int MAX_BARS   = 27;
	localparam int LUG_W      = 6;
	localparam int BAR_COUNT_DEF = 27;

	// Configuration register widths.
	localparam int PINS12_W = 51;
	localparam int PINS34_W = 44;
	localparam int PINS56_W = 36;
	localparam int BARS_A_W = 60;
	localparam int BARS_B_W = 60;
	localparam int BARS_C_W = 42;
	localparam int PINS_W   = PINS12_W + PINS34_W + PINS56_W;
	localparam int BARS_W   = BARS_A_W + BARS_B_W + BARS_C_W;
	localparam int PIDX_W   = $clog2(PINS_W);

	// APB port geometry: 64-bit registers at byte addresses 8*i.
	localparam int APB_DW = 64;
	localparam int APB_AW = 6;
	localparam int REG_IDX_W = 3;

	typedef enum logic [REG_IDX_W-1:0] {
		REG_PINS_12 = 3'd0,
		REG_PINS_34 = 3'd1,
		REG_PINS_56 = 3'd2,
		REG_BARS_A  = 3'd3,
		REG_BARS_B  = 3'd4,
		REG_BARS_C  = 3'd5
	} pwlc_reg_t;

	// Wheel lengths and the position of each wheel's first pin in the packed pin vector.
	localparam logic [POS_W-1:0] WHEEL_LEN [NUM_WHEELS] =
		'{5'd26, 5'd25, 5'd23, 5'd21, 5'd19, 5'd17};
	localparam logic [PIDX_W-1:0] WHEEL_BASE [NUM_WHEELS] =
		'{8'd0, 8'd26, 8'd51, 8'd74, 8'd95, 8'd114};

	// Whitespace codes.
	localparam logic [CHAR_W-1:0] CH_TAB   = 7'h09;
	localparam logic [CHAR_W-1:0] CH_LF    = 7'h0A;
	localparam logic [CHAR_W-1:0] CH_CR    = 7'h0D;
	localparam logic [CHAR_W-1:0] CH_SPACE = 7'h20;

	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

	// One classified word waiting for the key computation.
	typedef struct packed {
		logic [CHAR_W-1:0] in_char;
		logic [PAT_W-1:0]  pattern;
	} pwlc_job_t;

	typedef struct packed {
		logic      valid;
		pwlc_job_t job;
	} pwlc_push_t;

	typedef struct packed {
		logic empty;
		logic full;
	} pwlc_qstat_t;

	function automatic logic is_space(input logic [CHAR_W-1:0] c);
		return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_CR) || (c == CH_LF);
	endfunction

endpackage

### hdl/pwlc_if.sv
// Valid/ready channel interfaces for input and output characters.
interface pwlc_in_if;
	import pwlc_pkg::*;
	logic              valid;
	logic              ready;
	logic [CHAR_W-1:0] in_char;
	modport source (output valid, output in_char, input ready);
	modport sink (input valid, input in_char, output ready);
endinterface

interface pwlc_out_if;
	import pwlc_pkg::*;
	logic              valid;
	logic              ready;
	logic [CHAR_W-1:0] out_char;
	modport source (output valid, output out_char, input ready);
	modport sink (input valid, input out_char, output ready);
endinterface

### hdl/pinwheel_lug_cage_cipher_core.sv
// Top level of the pin-wheel and lug-cage cipher: register file and datapath wiring.
//
// Characters enter on in_ch and leave on out_ch, both valid/ready channels that
// move one word when valid and ready are high at a rising edge. Each input word
// gives exactly one output word, in order.
// A word accepted at one edge is written into the queue and then loaded into the
// output register, from which it appears on out_ch. One word per cycle is
// sustained while the receiver is ready; the front end steps all six wheels in
// the accepting cycle and the key stage counts up to 27 bars combinationally.
// The wheel pins and lug masks are loaded through the APB port, one 64-bit
// register at byte address 8*i; writes must be made while no words are in flight;
// the block does not enforce this. Reset clears the configuration registers,
// returns every wheel to position zero and empties the queue and output register.
// When the receiver stalls, the result holds on out_ch, the two-entry queue
// takes further words, and in_ch.ready drops once the queue is full.
module pinwheel_lug_cage_cipher_core #(
	parameter int BAR_COUNT = pwlc_pkg::BAR_COUNT_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	pwlc_in_if.sink                     in_ch,
	pwlc_out_if.source                  out_ch,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [pwlc_pkg::APB_AW-1:0] paddr,
	input  logic [pwlc_pkg::APB_DW-1:0] pwdata,
	output logic [pwlc_pkg::APB_DW-1:0] prdata,
	output logic                        pready
);
	import pwlc_pkg::*;

	logic [PINS12_W-1:0] pins12_q;
	logic [PINS34_W-1:0] pins34_q;
	logic [PINS56_W-1:0] pins56_q;
	logic [BARS_A_W-1:0] bars_a_q;
	logic [BARS_B_W-1:0] bars_b_q;
	logic [BARS_C_W-1:0] bars_c_q;
	pwlc_reg_t           reg_idx;
	logic                wr_en;
	pwlc_push_t          push;
	pwlc_qstat_t         qstat;
	pwlc_job_t           head;
	logic                pop;

	assign pready  = 1'b1;
	assign reg_idx = pwlc_reg_t'(paddr[APB_AW-1:APB_AW-REG_IDX_W]);
	assign wr_en   = psel && penable && pwrite && pready;

	// Register writes; addresses past the last register are ignored.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pins12_q <= '0;
			pins34_q <= '0;
			pins56_q <= '0;
			bars_a_q <= '0;
			bars_b_q <= '0;
			bars_c_q <= '0;
		end else if (wr_en) begin
			unique case (reg_idx)
				REG_PINS_12: pins12_q <= pwdata[PINS12_W-1:0];
				REG_PINS_34: pins34_q <= pwdata[PINS34_W-1:0];
				REG_PINS_56: pins56_q <= pwdata[PINS56_W-1:0];
				REG_BARS_A:  bars_a_q <= pwdata[BARS_A_W-1:0];
				REG_BARS_B:  bars_b_q <= pwdata[BARS_B_W-1:0];
				REG_BARS_C:  bars_c_q <= pwdata[BARS_C_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// Register read-back.
	always_comb begin
		unique case (reg_idx)
			REG_PINS_12: prdata = APB_DW'(pins12_q);
			REG_PINS_34: prdata = APB_DW'(pins34_q);
			REG_PINS_56: prdata = APB_DW'(pins56_q);
			REG_BARS_A:  prdata = APB_DW'(bars_a_q);
			REG_BARS_B:  prdata = APB_DW'(bars_b_q);
			REG_BARS_C:  prdata = APB_DW'(bars_c_q);
			default:     prdata = '0;
		endcase
	end

	pwlc_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_ch),
		.pins   ({pins56_q, pins34_q, pins12_q}),
		.qstat  (qstat),
		.push   (push)
	);

	pwlc_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.pop    (pop),
		.head   (head),
		.qstat  (qstat)
	);

	pwlc_back #(
		.BAR_COUNT (BAR_COUNT)
	) u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.head   (head),
		.qstat  (qstat),
		.bars   ({bars_c_q, bars_b_q, bars_a_q}),
		.pop    (pop),
		.out_ch (out_ch)
	);

endmodule

### hdl/pwlc_front.sv
// Front end: accepts words, reads the wheel pins and steps the wheels.
module pwlc_front (
	input  logic                    clk,
	input  logic                    arst_n,
	pwlc_in_if.sink                 in_ch,
	input  logic [pwlc_pkg::PINS_W-1:0] pins,
	input  pwlc_pkg::pwlc_qstat_t   qstat,
	output pwlc_pkg::pwlc_push_t    push
);
	import pwlc_pkg::*;

	logic [POS_W-1:0] pos_q [NUM_WHEELS];
	logic [PAT_W-1:0] pattern;
	logic             accept;

	assign in_ch.ready = !qstat.full;
	assign accept      = in_ch.valid && !qstat.full;

	// Each wheel shows the pin at its current position; wheel one is the top bit.
	for (genvar w = 0; w < NUM_WHEELS; w++) begin : g_wheel
		logic [PIDX_W-1:0] pin_idx;
		assign pin_idx = WHEEL_BASE[w] + PIDX_W'(pos_q[w]);
		assign pattern[PAT_W-1-w] = pins[pin_idx];

		// Every accepted word steps the wheel, wrapping at its length.
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				pos_q[w] <= '0;
			end else if (accept) begin
				if (pos_q[w] == WHEEL_LEN[w] - POS_W'(1)) begin
					pos_q[w] <= '0;
				end else begin
					pos_q[w] <= pos_q[w] + POS_W'(1);
				end
			end
		end
	end

	// Hand the word and its pattern to the queue.
	always_comb begin
		push.valid       = accept;
		push.job.in_char = in_ch.in_char;
		push.job.pattern = pattern;
	end

endmodule

### hdl/pwlc_queue.sv
// Two-entry queue between the front end and the key stage.
module pwlc_queue (
	input  logic                   clk,
	input  logic                   arst_n,
	input  pwlc_pkg::pwlc_push_t   push,
	input  logic                   pop,
	output pwlc_pkg::pwlc_job_t    head,
	output pwlc_pkg::pwlc_qstat_t  qstat
);
	import pwlc_pkg::*;

	pwlc_job_t         mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;

	assign head        = mem_q[rd_ptr_q];
	assign qstat.empty = (count_q == '0);
	assign qstat.full  = (count_q == QCNT_W'(QUEUE_DEPTH));

	// Storage is written at the tail only.
	always_ff @(posedge clk) begin
		if (push.valid) begin
			mem_q[wr_ptr_q] <= push.job;
		end
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push.valid) begin
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + QPTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + QPTR_W'(1);
			end
			if (push.valid && !pop) begin
				count_q <= count_q + QCNT_W'(1);
			end else if (pop && !push.valid) begin
				count_q <= count_q - QCNT_W'(1);
			end
		end
	end

endmodule

### hdl/pwlc_back.sv
// Back end: counts the engaged bars, transforms the character, holds the result.
module pwlc_back #(
	parameter int BAR_COUNT = pwlc_pkg::BAR_COUNT_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  pwlc_pkg::pwlc_job_t         head,
	input  pwlc_pkg::pwlc_qstat_t       qstat,
	input  logic [pwlc_pkg::BARS_W-1:0] bars,
	output logic                        pop,
	pwlc_out_if.source                  out_ch
);
	import pwlc_pkg::*;

	logic [MAX_BARS-1:0] hits;
	logic [LOW_W-1:0]    key;
	logic [CHAR_W-1:0]   coded;
	logic [CHAR_W-1:0]   result;
	logic                out_valid_q;
	logic [CHAR_W-1:0]   out_char_q;

	// A bar engages when its lug mask shares a bit with the pattern.
	for (genvar k = 0; k < MAX_BARS; k++) begin : g_bar
		if (k < BAR_COUNT) begin : g_used
			assign hits[k] = |(bars[LUG_W*k +: LUG_W] & head.pattern);
		end else begin : g_unused
			assign hits[k] = 1'b0;
		end
	end

	// Key number minus the low six bits, mod 64; whitespace in or out keeps the input.
	always_comb begin
		key    = LOW_W'($countones(hits));
		coded  = {head.in_char[CHAR_W-1], key - head.in_char[LOW_W-1:0]};
		result = (is_space(head.in_char) || is_space(coded)) ? head.in_char : coded;
	end

	assign pop = !qstat.empty && (!out_valid_q || out_ch.ready);

	// Output register: loads a queued word when it is empty or being taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (pop) begin
			out_valid_q <= 1'b1;
		end else if (out_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			out_char_q <= result;
		end
	end

	assign out_ch.valid    = out_valid_q;
	assign out_ch.out_char = out_char_q;

endmodule

### hdl/pwlc_checker.sv
// Port-level checks of the cipher core, attached by a bind statement.
module pwlc_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          in_valid,
	input logic                          in_ready,
	input logic [pwlc_pkg::CHAR_W-1:0]   in_char,
	input logic                          out_valid,
	input logic                          out_ready,
	input logic [pwlc_pkg::CHAR_W-1:0]   out_char
);
	import pwlc_pkg::*;

	// A stalled result stays offered.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("output word dropped while stalled");

	// A stalled result keeps its value.
	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(out_char))
		else $error("output word changed while stalled");

	// The queue can only be full behind a result that waits on the output.
	a_full_needs_out: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> out_valid)
		else $error("input stalled with the output register empty");

	// With the datapath empty, a whitespace word is loaded into the output register
	// at the edge after it is accepted and then shows up unchanged on out_char.
	a_space_pass: assert property (@(posedge clk) disable iff (!arst_n)
		!(in_valid && in_ready) ##1
		(in_valid && in_ready && !out_valid &&
		 (in_char == CH_SPACE || in_char == CH_TAB || in_char == CH_CR || in_char == CH_LF))
		|=> ##1 out_valid && out_char == $past(in_char, 2))
		else $error("whitespace word not passed through");

endmodule

bind pinwheel_lug_cage_cipher_core pwlc_checker u_pwlc_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_ch.valid),
	.in_ready  (in_ch.ready),
	.in_char   (in_ch.in_char),
	.out_valid (out_ch.valid),
	.out_ready (out_ch.ready),
	.out_char  (out_ch.out_char)
);
